FILE: hdl/fpr_pkg.sv
// Package with the constants and controller/datapath interface types of the fast packet reassembler.
package fpr_pkg;

    localparam int SLOTS       = 4;
    localparam int MAX_PAYLOAD = 256;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int POS_W       = $clog2(MAX_PAYLOAD);
    localparam int ADDR_W      = $clog2(SLOTS * MAX_PAYLOAD);
    localparam int KEY_W       = 28;

    localparam logic [7:0] FIRST_CHUNK = 8'd6;
    localparam logic [2:0] LATER_CHUNK = 3'd7;
    localparam logic [7:0] PF_PDU2     = 8'd240;
    localparam logic [4:0] INDEX_MASK  = 5'h1F;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_PGN    = 2'd1;
    localparam logic [1:0] CFG_SOURCE = 2'd2;

    typedef struct packed {
        logic load;
        logic check;
        logic write;
        logic emit;
    } fpr_cmd_t;

    typedef struct packed {
        logic drop;
        logic short_msg;
        logic complete;
        logic write_last;
        logic emit_done;
    } fpr_status_t;

endpackage

FILE: hdl/fast_packet_reassembler.sv
// Top level of the fast packet reassembler.
//
// Channel   Direction  Handshake                         Payload
// frame     in         start & !busy                     can_ident, extended_frame,
//                                                        data_length, frame_bytes
// result    out        result_valid, one cycle strobe    payload_word, word_bytes,
//                                                        message_source, message_pgn, last_word
// config    in         cfg_valid & cfg_ready             cfg_index, cfg_data
//
// A dropped or rejected frame ends in the check state; a stored frame then writes its chunk
// into the payload memory in the write state, one byte at a time.
// A short first frame gives its single result, registered in the check state.
// A completing frame then reads the payload memory one byte per cycle,
// with a word every 8 bytes.
// Reset clears the slot valid bits, the replace pointer and the filter registers.
// Results cannot be stalled; cfg_ready is always high.
module fast_packet_reassembler
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [28:0] can_ident,
    input  logic        extended_frame,
    input  logic [3:0]  data_length,
    input  logic [63:0] frame_bytes,
    output logic        result_valid,
    output logic [63:0] payload_word,
    output logic [3:0]  word_bytes,
    output logic [7:0]  message_source,
    output logic [16:0] message_pgn,
    output logic        last_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    fpr_pkg::fpr_cmd_t    cmd;
    fpr_pkg::fpr_status_t status;

    assign cfg_ready = 1'b1;

    fpr_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    fpr_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .can_ident      (can_ident),
        .extended_frame (extended_frame),
        .data_length    (data_length),
        .frame_bytes    (frame_bytes),
        .result_valid   (result_valid),
        .payload_word   (payload_word),
        .word_bytes     (word_bytes),
        .message_source (message_source),
        .message_pgn    (message_pgn),
        .last_word      (last_word)
    );

endmodule

FILE: hdl/fpr_ctrl.sv
// Controller state machine of the fast packet reassembler.
module fpr_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  fpr_pkg::fpr_status_t status,
    output fpr_pkg::fpr_cmd_t    cmd,
    output logic                busy
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
                if (start)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (status.drop || status.short_msg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write = 1'b1;
                if (status.write_last)
                begin
                    state_next = status.complete ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: hdl/fpr_datapath.sv
// Datapath of the fast packet reassembler: frame decode, slot table, payload memory and output words.
module fpr_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fpr_pkg::fpr_cmd_t    cmd,
    output fpr_pkg::fpr_status_t status,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic [28:0]          can_ident,
    input  logic                 extended_frame,
    input  logic [3:0]           data_length,
    input  logic [63:0]          frame_bytes,
    output logic                 result_valid,
    output logic [63:0]          payload_word,
    output logic [3:0]           word_bytes,
    output logic [7:0]           message_source,
    output logic [16:0]          message_pgn,
    output logic                 last_word
);

    localparam int SLOTS  = fpr_pkg::SLOTS;
    localparam int SLOT_W = fpr_pkg::SLOT_W;
    localparam int POS_W  = fpr_pkg::POS_W;
    localparam int ADDR_W = fpr_pkg::ADDR_W;
    localparam int AW1    = fpr_pkg::ADDR_W + 1;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [POS_W-1:0]  p);
        logic [ADDR_W:0] a;
        a = AW1'(s) * AW1'(fpr_pkg::MAX_PAYLOAD) + AW1'(p);
        return a[ADDR_W-1:0];
    endfunction

    logic                     filter_enable_reg;
    logic [16:0]              filter_pgn_reg;
    logic [7:0]               filter_source_reg;

    logic [28:0]              ident_reg;
    logic                     ext_reg;
    logic [3:0]               dlc_reg;
    logic [63:0]              frame_reg;

    logic [SLOTS-1:0]         slot_valid_reg;
    logic [fpr_pkg::KEY_W-1:0] slot_key_reg [SLOTS];
    logic [5:0]               slot_next_index_reg [SLOTS];
    logic [7:0]               slot_total_reg [SLOTS];
    logic [7:0]               slot_count_reg [SLOTS];
    logic [SLOT_W-1:0]        replace_ptr_reg;

    logic [7:0]               payload_mem [SLOTS * fpr_pkg::MAX_PAYLOAD];

    logic [SLOT_W-1:0]        wr_slot_reg;
    logic [7:0]               wr_pos_reg;
    logic [2:0]               wr_src_reg;
    logic [2:0]               wr_left_reg;
    logic                     complete_reg;
    logic [7:0]               emit_total_reg;
    logic [7:0]               rd_pos_reg;
    logic                     rd_valid_reg;
    logic [7:0]               rd_data_reg;
    logic [7:0]               recv_reg;
    logic [2:0]               lane_reg;
    logic [63:0]              word_acc_reg;

    logic                     result_valid_reg;
    logic [63:0]              payload_word_reg;
    logic [3:0]               word_bytes_reg;
    logic [7:0]               message_source_reg;
    logic [16:0]              message_pgn_reg;
    logic                     last_word_reg;

    logic [7:0]               src_c;
    logic [7:0]               pf_c;
    logic [16:0]              pgn_c;
    logic [2:0]               seq_c;
    logic [4:0]               idx_c;
    logic [fpr_pkg::KEY_W-1:0] key_c;
    logic [7:0]               total_c;
    logic                     hit_c;
    logic [SLOT_W-1:0]        hit_slot_c;
    logic                     free_c;
    logic [SLOT_W-1:0]        free_slot_c;
    logic [7:0]               sel_total_c;
    logic [7:0]               sel_count_c;
    logic [5:0]               sel_next_c;
    logic [7:0]               remaining_c;
    logic [2:0]               chunk_c;
    logic [8:0]               sum_c;
    logic                     complete_c;
    logic                     first_c;
    logic                     drop_c;
    logic                     short_c;
    logic [63:0]              short_word_c;
    logic [SLOT_W-1:0]        alloc_slot_c;
    logic                     issue_c;
    logic                     flush_c;
    logic                     final_c;
    logic [63:0]              word_out_c;

    always_comb
    begin
        src_c   = ident_reg[7:0];
        pf_c    = ident_reg[23:16];
        pgn_c   = {ident_reg[24], pf_c, (pf_c >= fpr_pkg::PF_PDU2) ? ident_reg[15:8] : 8'd0};
        seq_c   = frame_reg[7:5];
        idx_c   = frame_reg[4:0] & fpr_pkg::INDEX_MASK;
        key_c   = {src_c, pgn_c, seq_c};
        total_c = frame_reg[15:8];
        first_c = (idx_c == 5'd0);

        hit_c       = 1'b0;
        hit_slot_c  = '0;
        free_c      = 1'b0;
        free_slot_c = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (slot_valid_reg[s] && (slot_key_reg[s] == key_c))
            begin
                hit_c      = 1'b1;
                hit_slot_c = SLOT_W'(s);
            end
            if (!slot_valid_reg[s])
            begin
                free_c      = 1'b1;
                free_slot_c = SLOT_W'(s);
            end
        end

        sel_total_c = slot_total_reg[hit_slot_c];
        sel_count_c = slot_count_reg[hit_slot_c];
        sel_next_c  = slot_next_index_reg[hit_slot_c];
        remaining_c = sel_total_c - sel_count_c;
        chunk_c     = (remaining_c < 8'(fpr_pkg::LATER_CHUNK)) ? remaining_c[2:0]
                                                               : fpr_pkg::LATER_CHUNK;
        sum_c       = {1'b0, sel_count_c} + 9'(chunk_c);
        complete_c  = (sum_c >= {1'b0, sel_total_c});

        drop_c = !ext_reg || (dlc_reg < 4'd2)
              || (filter_enable_reg && ((pgn_c != filter_pgn_reg) || (src_c != filter_source_reg)))
              || (first_c && (9'(total_c) > 9'(fpr_pkg::MAX_PAYLOAD)))
              || (!first_c && (!hit_c || (sel_next_c != 6'(idx_c))));
        short_c = first_c && (total_c <= fpr_pkg::FIRST_CHUNK);

        short_word_c = '0;
        for (int b = 0; b < 6; b++)
        begin
            short_word_c[b*8 +: 8] = (8'(b) < total_c) ? frame_reg[(b+2)*8 +: 8] : 8'd0;
        end

        if (hit_c)
        begin
            alloc_slot_c = hit_slot_c;
        end
        else if (free_c)
        begin
            alloc_slot_c = free_slot_c;
        end
        else
        begin
            alloc_slot_c = replace_ptr_reg;
        end

        issue_c    = (rd_pos_reg < emit_total_reg);
        final_c    = (({1'b0, recv_reg} + 9'd1) == {1'b0, emit_total_reg});
        flush_c    = rd_valid_reg && ((lane_reg == 3'd7) || final_c);
        word_out_c = word_acc_reg | (64'(rd_data_reg) << {lane_reg, 3'b000});
    end

    always_comb
    begin
        status.drop       = drop_c;
        status.short_msg  = short_c;
        status.complete   = complete_reg;
        status.write_last = (wr_left_reg == 3'd1);
        status.emit_done  = rd_valid_reg && final_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg <= 1'b0;
            filter_pgn_reg    <= '0;
            filter_source_reg <= '0;
            slot_valid_reg    <= '0;
            replace_ptr_reg   <= '0;
            rd_valid_reg      <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    fpr_pkg::CFG_ENABLE: filter_enable_reg <= cfg_data[0];
                    fpr_pkg::CFG_PGN:    filter_pgn_reg    <= cfg_data[16:0];
                    fpr_pkg::CFG_SOURCE: filter_source_reg <= cfg_data[7:0];
                    default:             ;
                endcase
            end
            result_valid_reg <= flush_c || (cmd.check && !drop_c && first_c && short_c);
            rd_valid_reg     <= cmd.emit && issue_c;
            if (cmd.check && !drop_c)
            begin
                if (first_c && short_c)
                begin
                    if (hit_c)
                    begin
                        slot_valid_reg[hit_slot_c] <= 1'b0;
                    end
                end
                else if (first_c)
                begin
                    slot_valid_reg[alloc_slot_c] <= 1'b1;
                    if (!hit_c && !free_c)
                    begin
                        replace_ptr_reg <= (replace_ptr_reg == SLOT_W'(SLOTS - 1))
                                           ? '0 : replace_ptr_reg + 1'b1;
                    end
                end
                else if (complete_c)
                begin
                    slot_valid_reg[hit_slot_c] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ident_reg <= can_ident;
            ext_reg   <= extended_frame;
            dlc_reg   <= data_length;
            frame_reg <= frame_bytes;
        end
        if (cmd.check && !drop_c)
        begin
            if (first_c && short_c)
            begin
                payload_word_reg   <= short_word_c;
                word_bytes_reg     <= total_c[3:0];
                message_source_reg <= src_c;
                message_pgn_reg    <= pgn_c;
                last_word_reg      <= 1'b1;
            end
            else if (first_c)
            begin
                slot_key_reg[alloc_slot_c]        <= key_c;
                slot_next_index_reg[alloc_slot_c] <= 6'd1;
                slot_total_reg[alloc_slot_c]      <= total_c;
                slot_count_reg[alloc_slot_c]      <= fpr_pkg::FIRST_CHUNK;
                wr_slot_reg  <= alloc_slot_c;
                wr_pos_reg   <= '0;
                wr_src_reg   <= 3'd2;
                wr_left_reg  <= fpr_pkg::FIRST_CHUNK[2:0];
                complete_reg <= 1'b0;
            end
            else
            begin
                slot_next_index_reg[hit_slot_c] <= sel_next_c + 6'd1;
                slot_count_reg[hit_slot_c]      <= sum_c[7:0];
                wr_slot_reg    <= hit_slot_c;
                wr_pos_reg     <= sel_count_c;
                wr_src_reg     <= 3'd1;
                wr_left_reg    <= chunk_c;
                complete_reg   <= complete_c;
                emit_total_reg <= sel_total_c;
                rd_pos_reg     <= '0;
                recv_reg       <= '0;
                lane_reg       <= '0;
                word_acc_reg   <= '0;
            end
        end
        if (cmd.write)
        begin
            payload_mem[mem_addr(wr_slot_reg, wr_pos_reg[POS_W-1:0])]
                <= frame_reg[{wr_src_reg, 3'b000} +: 8];
            wr_pos_reg  <= wr_pos_reg + 8'd1;
            wr_src_reg  <= wr_src_reg + 3'd1;
            wr_left_reg <= wr_left_reg - 3'd1;
        end
        if (cmd.emit && issue_c)
        begin
            rd_data_reg <= payload_mem[mem_addr(wr_slot_reg, rd_pos_reg[POS_W-1:0])];
            rd_pos_reg  <= rd_pos_reg + 8'd1;
        end
        if (rd_valid_reg)
        begin
            recv_reg <= recv_reg + 8'd1;
            if (flush_c)
            begin
                payload_word_reg   <= word_out_c;
                word_bytes_reg     <= 4'(lane_reg) + 4'd1;
                message_source_reg <= src_c;
                message_pgn_reg    <= pgn_c;
                last_word_reg      <= final_c;
                word_acc_reg       <= '0;
                lane_reg           <= '0;
            end
            else
            begin
                word_acc_reg <= word_out_c;
                lane_reg     <= lane_reg + 3'd1;
            end
        end
    end

    assign result_valid   = result_valid_reg;
    assign payload_word   = payload_word_reg;
    assign word_bytes     = word_bytes_reg;
    assign message_source = message_source_reg;
    assign message_pgn    = message_pgn_reg;
    assign last_word      = last_word_reg;

endmodule

FILE: hdl/fpr_checker.sv
// Port-level checker of the fast packet reassembler and its bind statement.
module fpr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       result_valid,
    input logic [3:0] word_bytes,
    input logic       last_word
);

    a_bytes_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (word_bytes <= 4'd8))
        else $error("Result word carries more than eight bytes.");

    a_full_inner: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_word) |-> (word_bytes == 4'd8))
        else $error("A word before the last one is not full.");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (word_bytes == 4'd0)) |-> last_word)
        else $error("An empty word is not marked last.");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted transaction did not raise busy.");

endmodule

bind fast_packet_reassembler fpr_checker u_fpr_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .word_bytes   (word_bytes),
    .last_word    (last_word)
);

FILE: bench/testbench.sv
// Self-checking testbench for the fast packet reassembler with its own reassembly predictor.

typedef struct packed {
    logic [63:0] payload;
    logic [3:0]  count;
    logic [7:0]  source;
    logic [16:0] pgn;
    logic        last;
} payload_word_t;

class reassembly_scoreboard;
    bit            filter_on;
    bit [16:0]     filter_pgn_value;
    bit [7:0]      filter_source_value;
    bit            entry_valid [fpr_pkg::SLOTS];
    bit [fpr_pkg::KEY_W-1:0] entry_key  [fpr_pkg::SLOTS];
    bit [5:0]      entry_next  [fpr_pkg::SLOTS];
    bit [7:0]      entry_total [fpr_pkg::SLOTS];
    bit [7:0]      entry_count [fpr_pkg::SLOTS];
    bit [7:0]      entry_bytes [fpr_pkg::SLOTS][fpr_pkg::MAX_PAYLOAD];
    int            evict_slot;
    payload_word_t pending_words[$];
    int            mismatches;
    int            words_checked;
    int            messages_done;

    function void write_register(bit [1:0] index, bit [31:0] data);
        case (index)
            fpr_pkg::CFG_ENABLE: filter_on = data[0];
            fpr_pkg::CFG_PGN:    filter_pgn_value = data[16:0];
            fpr_pkg::CFG_SOURCE: filter_source_value = data[7:0];
            default: ;
        endcase
    endfunction

    function void queue_message(bit [7:0] buffer [fpr_pkg::MAX_PAYLOAD], int total,
                                bit [7:0] source, bit [16:0] pgn);
        int nwords;
        int cnt;
        payload_word_t w;
        nwords = (total + 7) / 8;
        if (nwords == 0)
            nwords = 1;
        for (int i = 0; i < nwords; i++)
        begin
            cnt = total - i * 8;
            if (cnt < 0)
                cnt = 0;
            if (cnt > 8)
                cnt = 8;
            w = '0;
            for (int b = 0; b < cnt; b++)
                w.payload[b*8 +: 8] = buffer[i*8 + b];
            w.count = 4'(cnt);
            w.source = source;
            w.pgn = pgn;
            w.last = (i + 1 == nwords);
            pending_words = {pending_words, w};
        end
        messages_done++;
    endfunction

    function void note_frame(bit [28:0] ident, bit extended, bit [3:0] dlc, bit [63:0] bytes);
        bit [7:0]   source;
        bit [7:0]   pf;
        bit [16:0]  pgn;
        bit [2:0]   seq;
        bit [4:0]   index;
        bit [fpr_pkg::KEY_W-1:0] key;
        int         hit;
        int         total;
        int         count;
        int         chunk;
        bit [7:0]   buffer [fpr_pkg::MAX_PAYLOAD];
        if (!extended || dlc < 2)
            return;
        source = ident[7:0];
        pf = ident[23:16];
        pgn = {ident[24], pf, 8'h00};
        if (pf >= fpr_pkg::PF_PDU2)
            pgn[7:0] = ident[15:8];
        if (filter_on && (pgn != filter_pgn_value || source != filter_source_value))
            return;
        seq = bytes[7:5];
        index = bytes[4:0] & fpr_pkg::INDEX_MASK;
        key = {source, pgn, seq};
        hit = -1;
        for (int s = 0; s < fpr_pkg::SLOTS; s++)
        begin
            if (hit < 0 && entry_valid[s] && entry_key[s] == key)
                hit = s;
        end
        if (index == 0)
        begin
            total = int'(bytes[15:8]);
            if (total > fpr_pkg::MAX_PAYLOAD)
                return;
            if (total <= fpr_pkg::FIRST_CHUNK)
            begin
                for (int i = 0; i < total; i++)
                    buffer[i] = bytes[(2 + i)*8 +: 8];
                if (hit >= 0)
                    entry_valid[hit] = 0;
                queue_message(buffer, total, source, pgn);
                return;
            end
            for (int s = 0; s < fpr_pkg::SLOTS; s++)
            begin
                if (hit < 0 && !entry_valid[s])
                    hit = s;
            end
            if (hit < 0)
            begin
                hit = evict_slot;
                evict_slot = (evict_slot + 1) % fpr_pkg::SLOTS;
            end
            entry_valid[hit] = 1;
            entry_key[hit] = key;
            entry_next[hit] = 1;
            entry_total[hit] = 8'(total);
            entry_count[hit] = fpr_pkg::FIRST_CHUNK;
            for (int i = 0; i < fpr_pkg::FIRST_CHUNK; i++)
                entry_bytes[hit][i] = bytes[(2 + i)*8 +: 8];
        end
        else
        begin
            if (hit < 0 || entry_next[hit] != index)
                return;
            total = entry_total[hit];
            count = entry_count[hit];
            chunk = (total > count) ? total - count : 0;
            if (chunk > fpr_pkg::LATER_CHUNK)
                chunk = fpr_pkg::LATER_CHUNK;
            for (int i = 0; i < chunk; i++)
                entry_bytes[hit][count + i] = bytes[(1 + i)*8 +: 8];
            count += chunk;
            entry_count[hit] = 8'(count);
            entry_next[hit] = entry_next[hit] + 6'd1;
            if (count >= total)
            begin
                entry_valid[hit] = 0;
                for (int i = 0; i < total; i++)
                    buffer[i] = entry_bytes[hit][i];
                queue_message(buffer, total, source, pgn);
            end
        end
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
        mismatches++;
    endtask

    task check_word(payload_word_t got);
        payload_word_t want;
        words_checked++;
        if (pending_words.size() == 0)
        begin
            report_mismatch("unexpected result", got.payload, 64'd0);
            return;
        end
        want = pending_words.pop_front();
        if (got.payload !== want.payload)
            report_mismatch("payload_word", got.payload, want.payload);
        if (got.count !== want.count)
            report_mismatch("word_bytes", 64'(got.count), 64'(want.count));
        if (got.source !== want.source)
            report_mismatch("message_source", 64'(got.source), 64'(want.source));
        if (got.pgn !== want.pgn)
            report_mismatch("message_pgn", 64'(got.pgn), 64'(want.pgn));
        if (got.last !== want.last)
            report_mismatch("last_word", 64'(got.last), 64'(want.last));
    endtask
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 75;
    localparam int WATCHDOG_LIMIT  = 5000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [28:0] can_ident;
    logic        extended_frame;
    logic [3:0]  data_length;
    logic [63:0] frame_bytes;
    logic        result_valid;
    logic [63:0] payload_word;
    logic [3:0]  word_bytes;
    logic [7:0]  message_source;
    logic [16:0] message_pgn;
    logic        last_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    reassembly_scoreboard sb;
    int          burst_left;
    int          frames_sent;
    int          idle_cycles;
    bit [28:0]   ident_pool [6];
    bit          msg_open  [5];
    bit [28:0]   msg_ident [5];
    bit [2:0]    msg_seq   [5];
    bit [7:0]    msg_total [5];
    int          msg_next  [5];

    fast_packet_reassembler u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .can_ident(can_ident), .extended_frame(extended_frame),
        .data_length(data_length), .frame_bytes(frame_bytes),
        .result_valid(result_valid), .payload_word(payload_word),
        .word_bytes(word_bytes), .message_source(message_source),
        .message_pgn(message_pgn), .last_word(last_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_word({payload_word, word_bytes, message_source, message_pgn, last_word});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic bit [16:0] pgn_of(bit [28:0] ident);
        bit [16:0] pgn;
        pgn = {ident[24], ident[23:16], 8'h00};
        if (ident[23:16] >= fpr_pkg::PF_PDU2)
            pgn[7:0] = ident[15:8];
        return pgn;
    endfunction

    function automatic bit [63:0] frame_data(bit [2:0] seq, int index, bit [7:0] total);
        bit [63:0] data;
        data = {$urandom, $urandom};
        data[7:0] = {seq, index[4:0]};
        if (index == 0)
            data[15:8] = total;
        return data;
    endfunction

    task automatic send_frame(bit [28:0] ident, bit extended, bit [3:0] dlc, bit [63:0] data);
        @(negedge clk);
        start <= 1;
        can_ident <= ident;
        extended_frame <= extended;
        data_length <= dlc;
        frame_bytes <= data;
        do
            @(posedge clk);
        while (busy);
        sb.note_frame(ident, extended, dlc, data);
        frames_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            @(negedge clk);
            start <= 0;
            repeat ($urandom_range(0, 12))
                @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(0, 6);
        end
    endtask

    task automatic send_good(bit [28:0] ident, bit [2:0] seq, int index, bit [7:0] total);
        send_frame(ident, 1, ($urandom_range(0, 4) == 0) ? 4'($urandom_range(2, 15)) : 4'd8,
                   frame_data(seq, index, total));
    endtask

    task automatic drain_and_settle();
        @(negedge clk);
        start <= 0;
        while (sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    task automatic write_register(bit [1:0] index, bit [31:0] data);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= index;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_register(index, data);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic set_filter(bit enable, bit [28:0] ident);
        drain_and_settle();
        write_register(fpr_pkg::CFG_ENABLE, 32'(enable));
        write_register(fpr_pkg::CFG_PGN, 32'(pgn_of(ident)));
        write_register(fpr_pkg::CFG_SOURCE, 32'(ident[7:0]));
    endtask

    task automatic random_phase(int count);
        int good;
        int m;
        good = 0;
        while (good < count)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                send_frame(29'($urandom), 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                           {$urandom, $urandom});
                continue;
            end
            m = $urandom_range(0, 4);
            if (!msg_open[m])
            begin
                msg_open[m] = 1;
                msg_ident[m] = ident_pool[$urandom_range(0, 5)];
                msg_seq[m] = 3'($urandom);
                msg_total[m] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(41, 255))
                                                          : 8'($urandom_range(0, 40));
                msg_next[m] = 0;
            end
            if ($urandom_range(0, 19) == 0)
                send_good(msg_ident[m], msg_seq[m], $urandom_range(0, 31), 8'($urandom));
            else
            begin
                send_good(msg_ident[m], msg_seq[m], msg_next[m], msg_total[m]);
                msg_next[m]++;
                if (6 + 7 * (msg_next[m] - 1) >= msg_total[m] || msg_next[m] == 32)
                    msg_open[m] = 0;
            end
            good++;
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        start = 0;
        can_ident = '0;
        extended_frame = 0;
        data_length = '0;
        frame_bytes = '0;
        cfg_valid = 0;
        cfg_index = fpr_pkg::CFG_ENABLE;
        cfg_data = '0;
        burst_left = 0;
        frames_sent = 0;
        ident_pool[0] = 29'h1FFF_FFFF;
        ident_pool[1] = 29'h0;
        ident_pool[2] = {3'd6, 2'b00, 8'hEF, 8'h12, 8'h33};
        ident_pool[3] = {3'd2, 2'b00, 8'hEF, 8'hA5, 8'h33};
        ident_pool[4] = {3'd3, 2'b01, 8'hF1, 8'h0C, 8'h80};
        ident_pool[5] = 29'($urandom);
        for (int i = 0; i < 5; i++)
            msg_open[i] = 0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        write_register(fpr_pkg::CFG_ENABLE, 32'd0);
        write_register(fpr_pkg::CFG_PGN, 32'h1FFFF);
        write_register(fpr_pkg::CFG_SOURCE, 32'hFF);

        // Directed frames: drops, short and empty messages, ordering and slot replacement.
        send_frame(ident_pool[2], 0, 8, frame_data(0, 0, 3));
        send_frame(ident_pool[2], 1, 1, frame_data(0, 0, 3));
        send_frame(ident_pool[2], 1, 0, frame_data(0, 0, 3));
        send_good(ident_pool[2], 1, 3, 0);
        send_good(ident_pool[0], 7, 0, 0);
        send_good(ident_pool[1], 0, 0, 6);
        send_good(ident_pool[2], 2, 0, 7);
        send_good(ident_pool[2], 2, 2, 0);
        send_good(ident_pool[3], 2, 1, 0);
        send_frame(ident_pool[4], 1, 15, frame_data(5, 0, 13));
        send_frame(ident_pool[4], 1, 15, frame_data(5, 1, 0));
        for (int i = 0; i < 5; i++)
            send_good(ident_pool[4], 3'(i), 0, 20);
        for (int i = 0; i < 5; i++)
            send_good(ident_pool[4], 3'(i), 1, 0);
        send_good(ident_pool[4], 1, 0, 2);

        random_phase(ITEMS_PER_PHASE);
        set_filter(1, ident_pool[0]);
        random_phase(ITEMS_PER_PHASE);
        set_filter(1, ident_pool[1]);
        random_phase(ITEMS_PER_PHASE);
        set_filter(0, ident_pool[2]);
        random_phase(ITEMS_PER_PHASE);

        drain_and_settle();
        repeat (30)
            @(posedge clk);
        $display("Sent %0d frames over four filter settings; %0d messages, %0d words checked.",
                 frames_sent, sb.messages_done, sb.words_checked);
        if (sb.mismatches == 0 && sb.pending_words.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
